// ===== hdl/bgm_pkg.sv =====
// ----------------------------------------------------------------------------
// bgm_pkg
// Shared types and constants for the bitmap glyph mask expander.
// ----------------------------------------------------------------------------
package bgm_pkg;

  // Default sizes of the font store and the output cell
  localparam int GLYPH_SLOTS_DEF     = 256;
  localparam int MAX_GLYPH_ROWS_DEF  = 32;
  localparam int MAX_CELL_PIXELS_DEF = 64;

  // Field widths fixed by the interface
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int MASK_W     = 64;
  localparam int ROW_OUT_W  = 6;
  localparam int CELL_W     = 7;
  localparam int ZOOM_W     = 5;
  localparam int GW_W       = 5;
  localparam int GH_W       = 6;
  localparam int LOADED_W   = 9;
  localparam int CODE_W     = 8;
  localparam int PAT_W      = 8;
  localparam int FROW_W     = 5;

  // Divider operands: cell size (<= 64) times zoom (<= 16), by a glyph size
  localparam int DIVD_W = 11;
  localparam int DIVS_W = 6;

  // Reset values of the configuration registers
  localparam logic [CELL_W-1:0]   CELL_W_RST   = 7'd8;
  localparam logic [CELL_W-1:0]   CELL_H_RST   = 7'd16;
  localparam logic [ZOOM_W-1:0]   ZOOM_RST     = 5'd1;
  localparam logic [GW_W-1:0]     GLYPH_W_RST  = 5'd8;
  localparam logic [GH_W-1:0]     GLYPH_H_RST  = 6'd16;
  localparam logic [LOADED_W-1:0] LOADED_RST   = 9'd256;

  localparam logic [ZOOM_W-1:0]   ZOOM_MAX     = 5'd16;

  // Ninth-column duplication: line-drawing codes of a 9-wide glyph
  localparam logic [CODE_W-1:0]   DUP_CODE_LO  = 8'd192;
  localparam logic [CODE_W-1:0]   DUP_CODE_HI  = 8'd223;
  localparam logic [GW_W-1:0]     DUP_GLYPH_W  = 5'd9;
  localparam int                  FONT_COLS    = 8;

  // Column map codes: 0..7 select a font bit, COL_DUP copies bit 0
  localparam int                  COL_CODE_W   = 4;
  localparam logic [COL_CODE_W-1:0] COL_DUP    = 4'd8;
  localparam logic [COL_CODE_W-1:0] COL_NONE   = 4'hF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH    = 3'd0,
    REG_CELL_HEIGHT   = 3'd1,
    REG_ZOOM          = 3'd2,
    REG_GLYPH_WIDTH   = 3'd3,
    REG_GLYPH_HEIGHT  = 3'd4,
    REG_NINE_COL_DUP  = 3'd5,
    REG_GLYPHS_LOADED = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_COLMAP,
    ST_ROW_RD,
    ST_ROW_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/bitmap_glyph_mask_expander_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_glyph_mask_expander_top
// Scaled text-mode character generator: font store plus glyph mask expander.
// ----------------------------------------------------------------------------
// A write word (operation 0) stores one 8-bit font row; the store is
// undefined until written and has no clearing pass. A render word
// (operation 1) stalls the input until its final row is loaded: one shared
// restoring divider works out the font pixel width and then its height, one
// bit a cycle, a sweep over all MAX_CELL_PIXELS column positions builds the
// column map, and each cell row then takes a font store read and then a load
// of the output register. Rows leave through an output register, so a
// stalled result does not block the next write word.
// ----------------------------------------------------------------------------
module bitmap_glyph_mask_expander_top #(
  parameter int GLYPH_SLOTS     = bgm_pkg::GLYPH_SLOTS_DEF,
  parameter int MAX_GLYPH_ROWS  = bgm_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int MAX_CELL_PIXELS = bgm_pkg::MAX_CELL_PIXELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [bgm_pkg::CODE_W-1:0]        in_glyph_index,
  input  logic [bgm_pkg::FROW_W-1:0]        in_font_row,
  input  logic [bgm_pkg::PAT_W-1:0]         in_row_pattern,
  // result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bgm_pkg::MASK_W-1:0]        out_mask_bits,
  output logic [bgm_pkg::ROW_OUT_W-1:0]     out_mask_row,
  output logic                              out_last_row,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import bgm_pkg::*;

  // Only slots reachable by an 8-bit code need storage
  localparam int SLOTS_USED = (GLYPH_SLOTS < 256) ? GLYPH_SLOTS : 256;
  localparam int DEPTH      = SLOTS_USED * MAX_GLYPH_ROWS;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW         = $clog2(MAX_CELL_PIXELS + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0]   cell_width_r;
  logic [CELL_W-1:0]   cell_height_r;
  logic [ZOOM_W-1:0]   zoom_r;
  logic [GW_W-1:0]     glyph_width_r;
  logic [GH_W-1:0]     glyph_height_r;
  logic                nine_dup_r;
  logic [LOADED_W-1:0] loaded_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r   <= CELL_W_RST;
      cell_height_r  <= CELL_H_RST;
      zoom_r         <= ZOOM_RST;
      glyph_width_r  <= GLYPH_W_RST;
      glyph_height_r <= GLYPH_H_RST;
      nine_dup_r     <= 1'b0;
      loaded_r       <= LOADED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CELL_WIDTH:    cell_width_r   <= cfg_data[CELL_W-1:0];
        REG_CELL_HEIGHT:   cell_height_r  <= cfg_data[CELL_W-1:0];
        REG_ZOOM:          zoom_r         <= cfg_data[ZOOM_W-1:0];
        REG_GLYPH_WIDTH:   glyph_width_r  <= cfg_data[GW_W-1:0];
        REG_GLYPH_HEIGHT:  glyph_height_r <= cfg_data[GH_W-1:0];
        REG_NINE_COL_DUP:  nine_dup_r     <= cfg_data[0];
        REG_GLYPHS_LOADED: loaded_r       <= cfg_data[LOADED_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped working values of the configuration
  logic [CELL_W-1:0] cw, ch;
  logic [ZOOM_W-1:0] sc;
  logic [GW_W-1:0]   gw_div;
  logic [GH_W-1:0]   gh_div;
  logic              dup_ok;

  always_comb begin
    cw = (cell_width_r == '0) ? CELL_W'(1) :
         (int'(cell_width_r) > MAX_CELL_PIXELS) ? CELL_W'(MAX_CELL_PIXELS) : cell_width_r;
    ch = (cell_height_r == '0) ? CELL_W'(1) :
         (int'(cell_height_r) > MAX_CELL_PIXELS) ? CELL_W'(MAX_CELL_PIXELS) : cell_height_r;
    sc = (zoom_r == '0) ? ZOOM_W'(1) : (zoom_r > ZOOM_MAX) ? ZOOM_MAX : zoom_r;
    gw_div = (glyph_width_r == '0) ? GW_W'(1) : glyph_width_r;
    gh_div = (glyph_height_r == '0) ? GH_W'(1) : glyph_height_r;
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic                 sel_h_r, sel_h_nxt;      // second division: pixel height
  logic [CODE_W-1:0]    gi_r, gi_nxt;
  logic                 blank_r, blank_nxt;
  logic [DIVD_W-1:0]    prod_r, prod_nxt;
  logic [DIVD_W-1:0]    pxw_r, pxw_nxt;
  logic [DIVD_W-1:0]    pxh_r, pxh_nxt;
  logic [XW-1:0]        x_r, x_nxt;              // column sweep position
  logic [DIVD_W-1:0]    sub_r, sub_nxt;          // position within a font pixel
  logic [CELL_W-1:0]    gx_r, gx_nxt;            // font column / font row
  logic [CELL_W-1:0]    y_r, y_nxt;
  logic [COL_CODE_W-1:0] col_r   [MAX_CELL_PIXELS];
  logic [COL_CODE_W-1:0] col_nxt [MAX_CELL_PIXELS];

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]    out_bits_r, out_bits_nxt;
  logic [ROW_OUT_W-1:0] out_row_r, out_row_nxt;
  logic                 out_last_r, out_last_nxt;

  // Shared divider and font store
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [PAT_W-1:0]     ram_rdata;

  bgm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bgm_ram #(
    .WIDTH (PAT_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_row_pattern),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic                  accept;
  logic                  row_ok;
  logic [COL_CODE_W-1:0] col_code;
  logic [MASK_W-1:0]     mask_w;
  logic                  out_load;
  logic                  row_last;
  logic [DIVD_W-1:0]     quo_clamped;

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state_r != ST_IDLE);
  assign quo_clamped = (div_rsp.quotient == '0) ? DIVD_W'(1) : div_rsp.quotient;

  // Write: drop rows that fall outside the store
  assign ram_we    = accept && (op_t'(in_operation) == OP_WRITE) &&
                     (int'(in_glyph_index) < GLYPH_SLOTS) &&
                     (int'(in_font_row) < MAX_GLYPH_ROWS);
  assign ram_waddr = AW'(int'(in_glyph_index) * MAX_GLYPH_ROWS + int'(in_font_row));

  // gx_r holds the font row during the row phase
  assign row_ok    = !blank_r && (gx_r < CELL_W'(glyph_height_r)) &&
                     (int'(gx_r) < MAX_GLYPH_ROWS);
  assign ram_raddr = row_ok ? AW'(int'(gi_r) * MAX_GLYPH_ROWS + int'(gx_r)) : '0;

  assign dup_ok = nine_dup_r && (glyph_width_r == DUP_GLYPH_W) &&
                  (gi_r inside {[DUP_CODE_LO:DUP_CODE_HI]});

  // Column map entry for the column under the sweep
  always_comb begin
    col_code = COL_NONE;
    if ((CELL_W'(x_r) < cw) && (gx_r < CELL_W'(glyph_width_r))) begin
      if (int'(gx_r) < FONT_COLS) begin
        col_code = COL_CODE_W'(gx_r);
      end else if ((int'(gx_r) == FONT_COLS) && dup_ok) begin
        col_code = COL_DUP;
      end
    end
  end

  // Expand the font row through the column map
  always_comb begin
    mask_w = '0;
    for (int i = 0; i < MAX_CELL_PIXELS; i++) begin
      if (row_ok && (col_r[i] != COL_NONE)) begin
        if (col_r[i] == COL_DUP) begin
          mask_w[i] = ram_rdata[0];
        end else begin
          mask_w[i] = ram_rdata[3'd7 - col_r[i][2:0]];
        end
      end
    end
  end

  assign row_last = (y_r + 1'b1 == ch);
  assign out_load = (state_r == ST_ROW_OUT) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    sel_h_nxt = sel_h_r;
    gi_nxt    = gi_r;
    blank_nxt = blank_r;
    prod_nxt  = prod_r;
    pxw_nxt   = pxw_r;
    pxh_nxt   = pxh_r;
    x_nxt     = x_r;
    sub_nxt   = sub_r;
    gx_nxt    = gx_r;
    y_nxt     = y_r;
    col_nxt   = col_r;

    div_req.start    = (state_r == ST_DIV_START);
    div_req.dividend = prod_r;
    div_req.divisor  = sel_h_r ? gh_div : DIVS_W'(gw_div);

    out_valid_nxt = out_valid_r && out_stall;
    out_bits_nxt  = out_bits_r;
    out_row_nxt   = out_row_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept && (op_t'(in_operation) == OP_RENDER)) begin
          gi_nxt    = in_glyph_index;
          blank_nxt = (CODE_W'(in_glyph_index) >= loaded_r) ||
                      (int'(in_glyph_index) >= GLYPH_SLOTS);
          sel_h_nxt = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = (sel_h_r ? DIVD_W'(ch) : DIVD_W'(cw)) * DIVD_W'(sc);
        state_nxt = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (!sel_h_r) begin
            pxw_nxt   = quo_clamped;
            sel_h_nxt = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            pxh_nxt   = quo_clamped;
            x_nxt     = '0;
            sub_nxt   = '0;
            gx_nxt    = '0;
            state_nxt = ST_COLMAP;
          end
        end
      end
      ST_COLMAP: begin
        // shift the map down, new column enters at the top
        for (int i = 0; i < MAX_CELL_PIXELS - 1; i++) begin
          col_nxt[i] = col_r[i+1];
        end
        col_nxt[MAX_CELL_PIXELS-1] = col_code;
        if (sub_r + 1'b1 == pxw_r) begin
          sub_nxt = '0;
          gx_nxt  = gx_r + 1'b1;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
        x_nxt = x_r + 1'b1;
        if (int'(x_r) == MAX_CELL_PIXELS - 1) begin
          sub_nxt   = '0;
          gx_nxt    = '0;
          y_nxt     = '0;
          state_nxt = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        state_nxt = ST_ROW_OUT;
      end
      ST_ROW_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = mask_w;
          out_row_nxt   = y_r[ROW_OUT_W-1:0];
          out_last_nxt  = row_last;
          y_nxt         = y_r + 1'b1;
          if (sub_r + 1'b1 == pxh_r) begin
            sub_nxt = '0;
            gx_nxt  = gx_r + 1'b1;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
          state_nxt = row_last ? ST_IDLE : ST_ROW_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_h_r    <= sel_h_nxt;
    gi_r       <= gi_nxt;
    blank_r    <= blank_nxt;
    prod_r     <= prod_nxt;
    pxw_r      <= pxw_nxt;
    pxh_r      <= pxh_nxt;
    x_r        <= x_nxt;
    sub_r      <= sub_nxt;
    gx_r       <= gx_nxt;
    y_r        <= y_nxt;
    col_r      <= col_nxt;
    out_bits_r <= out_bits_nxt;
    out_row_r  <= out_row_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_mask_bits = out_bits_r;
  assign out_mask_row  = out_row_r;
  assign out_last_row  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Loading the final row ends the render
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && row_last |=> state_r == ST_IDLE)
    else $error("render did not end after its final row");

  // The divider answers only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV_WAIT)
    else $error("divider result arrived outside the wait state");

  // The font store is never written during a render
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE)
    else $error("font store written while rendering");

endmodule

// ===== hdl/bgm_ram.sv =====
// ----------------------------------------------------------------------------
// bgm_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bgm_div.sv =====
// ----------------------------------------------------------------------------
// bgm_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bgm_pkg::div_req_t req,
  output bgm_pkg::div_rsp_t rsp
);

  import bgm_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   rem_sh;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVD_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = CNT_W'(DIVD_W);
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      quo_nxt  = {quo_r[DIVD_W-2:0], ge};
      rem_nxt  = ge ? DIVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVS_W-1:0];
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
